// File: design/buddy_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared assertion forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// condition holds at every edge out of reset
`define BPA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, status codes, payload types and bitmap layout helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_COUNT  = 4096;
    localparam int TOP_ORDER   = 10;
    localparam int ORDER_SLOTS = TOP_ORDER + 1;
    localparam int TOP_BLOCKS  = PAGE_COUNT >> TOP_ORDER;
    localparam int POOL_PAGES  = TOP_BLOCKS << TOP_ORDER;

    localparam int WORD_W = 64;
    localparam int BIT_W  = $clog2(WORD_W);

    localparam int FUNC_W = 1;
    localparam int ORD_W  = 4;
    localparam int PG_W   = 12;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;

    localparam int QD   = 2;
    localparam int QP_W = 1;
    localparam int QC_W = 2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MEM    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ORD_W-1:0]  order;
        logic [PG_W-1:0]   block_page;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PG_W-1:0]   page_index;
        logic [CNT_W-1:0]  pages_free;
        logic [CNT_W-1:0]  used_pages;
        logic [CNT_W-1:0]  peak_pages;
        logic [ORD_W-1:0]  max_free_order;
    } rsp_t;

    typedef struct packed {
        logic bad;
        req_t req;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
        logic take;
    } bk_ctl_t;

    function automatic int rgn_words(int k);
        int b;
        b = PAGE_COUNT >> k;
        return (b + WORD_W - 1) / WORD_W;
    endfunction

    function automatic int rgn_base(int k);
        int s;
        s = 0;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            if (i < k)
            begin
                s = s + rgn_words(i);
            end
        end
        return s;
    endfunction

    localparam int NWORDS = rgn_base(ORDER_SLOTS);
    localparam int MAP_AW = $clog2(NWORDS);

    function automatic logic [WORD_W-1:0] map_reset_word(int a);
        logic [WORD_W-1:0] w;
        int off;
        w   = '0;
        off = a - rgn_base(TOP_ORDER);
        if (off >= 0)
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                if (off * WORD_W + i < TOP_BLOCKS)
                begin
                    w[i] = 1'b1;
                end
            end
        end
        return w;
    endfunction

    function automatic logic [NWORDS-1:0] sum_reset();
        logic [NWORDS-1:0] s;
        for (int a = 0; a < NWORDS; a++)
        begin
            s[a] = |map_reset_word(a);
        end
        return s;
    endfunction

    localparam logic [NWORDS-1:0] SUM_INIT = sum_reset();

    function automatic logic [MAP_AW-1:0] map_addr(logic [ORD_W-1:0] k, logic [PG_W-1:0] pg);
        logic [PG_W-1:0] n;
        n = pg >> k;
        return MAP_AW'(rgn_base(int'(k)) + int'(n >> BIT_W));
    endfunction

    function automatic logic [BIT_W-1:0] map_bit(logic [ORD_W-1:0] k, logic [PG_W-1:0] pg);
        logic [PG_W-1:0] n;
        n = pg >> k;
        return n[BIT_W-1:0];
    endfunction

endpackage

// File: design/buddy_page_allocator.sv
// Flow: an allocate passes a take state, a split state per order split and a head write;
// an in-pool free passes a head check and a merge state per order merged; a bad order or no
// memory goes straight to completion. The engine runs one request at a time; a two-entry queue
// buffers requests and a result is held until popped. Reset: asynchronous; a clearing
// pass over the head table and free bitmap, with full held high, precedes the first request.
// ----------------------------------------------------------------------------
// Buddy page allocator top level
// Front end queue plus allocation engine with a result register.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpa_pkg::req_t req,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output bpa_pkg::rsp_t rsp
);

    bpa_pkg::bk_ctl_t ctl;
    bpa_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             rsp_valid;

    bpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .ctl       (ctl),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    bpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ctl       (ctl),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_pop   (pop)
    );

    assign empty = !rsp_valid;

endmodule

// File: design/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bpa_front.sv
// ----------------------------------------------------------------------------
// Buddy page allocator front end
// Accepts requests, flags bad orders and buffers them for the engine.
// ----------------------------------------------------------------------------
module bpa_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bpa_pkg::req_t    req,
    output logic             full,
    input  bpa_pkg::bk_ctl_t ctl,
    output logic             cmd_valid,
    output bpa_pkg::cmd_t    cmd
);

    bpa_pkg::cmd_t                q_reg [bpa_pkg::QD];
    logic [bpa_pkg::QP_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bpa_pkg::QP_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bpa_pkg::QC_W-1:0]     cnt_reg, cnt_next;
    logic                         acc;
    logic                         pop_q;
    bpa_pkg::cmd_t                cls;

    assign full      = (cnt_reg == bpa_pkg::QC_W'(bpa_pkg::QD)) || ctl.init_busy;
    assign acc       = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop_q     = ctl.take && cmd_valid;

    always_comb
    begin
        cls.req = req;
        cls.bad = (req.order > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
        wr_ptr_next = acc ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_q ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + bpa_pkg::QC_W'(acc) - bpa_pkg::QC_W'(pop_q);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: design/bpa_back.sv
// ----------------------------------------------------------------------------
// Buddy page allocator engine
// Runs allocate and free requests over the free bitmap and head table.
// ----------------------------------------------------------------------------
module bpa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  bpa_pkg::cmd_t    cmd,
    output bpa_pkg::bk_ctl_t ctl,
    output logic             rsp_valid,
    output bpa_pkg::rsp_t    rsp,
    input  logic             rsp_pop
);

`include "buddy_page_allocator_defines.svh"

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ATAKE  = 3'd2;
    localparam logic [2:0] S_ASPLIT = 3'd3;
    localparam logic [2:0] S_AHEAD  = 3'd4;
    localparam logic [2:0] S_FCHK   = 3'd5;
    localparam logic [2:0] S_FMERGE = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [bpa_pkg::PG_W-1:0]        clr_reg, clr_next;
    logic [bpa_pkg::ORD_W-1:0]       ord_reg, ord_next;
    logic [bpa_pkg::PG_W-1:0]        pg_reg, pg_next;
    logic [bpa_pkg::ORD_W-1:0]       lvl_reg, lvl_next;
    logic [bpa_pkg::MAP_AW-1:0]      word_reg, word_next;
    logic [bpa_pkg::STAT_W-1:0]      stat_reg, stat_next;
    logic [bpa_pkg::CNT_W-1:0]       cnt_reg [bpa_pkg::ORDER_SLOTS];
    logic [bpa_pkg::CNT_W-1:0]       cnt_next [bpa_pkg::ORDER_SLOTS];
    logic [bpa_pkg::NWORDS-1:0]      sum_reg, sum_next;
    logic [bpa_pkg::CNT_W-1:0]       free_reg, free_next;
    logic [bpa_pkg::CNT_W-1:0]       used_reg, used_next;
    logic [bpa_pkg::CNT_W-1:0]       peak_reg, peak_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    bpa_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            m_we;
    logic [bpa_pkg::MAP_AW-1:0]      m_waddr, m_raddr;
    logic [bpa_pkg::WORD_W-1:0]      m_wdata, m_rdata;
    logic                            h_we;
    logic [bpa_pkg::PG_W-1:0]        h_waddr, h_raddr;
    logic [bpa_pkg::ORD_W-1:0]       h_wdata, h_rdata;

    logic [bpa_pkg::ORD_W-1:0]       kf;
    logic                            kf_ok;
    logic [bpa_pkg::MAP_AW-1:0]      wf;
    logic                            wf_ok;
    int                              lo, hi;
    logic [bpa_pkg::BIT_W-1:0]       fb;
    logic [bpa_pkg::ORD_W-1:0]       lg;
    logic [bpa_pkg::PG_W-1:0]        pg_a, q_a, q_n;
    logic [bpa_pkg::BIT_W-1:0]       bm;
    logic [bpa_pkg::CNT_W-1:0]       sz;

    bpa_ram #(.WIDTH(bpa_pkg::WORD_W), .DEPTH(bpa_pkg::NWORDS)) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    bpa_ram #(.WIDTH(bpa_pkg::ORD_W), .DEPTH(bpa_pkg::PAGE_COUNT)) u_head (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // smallest order with a free block at or above the request
    always_comb
    begin
        kf    = '0;
        kf_ok = 1'b0;
        for (int k = bpa_pkg::TOP_ORDER; k >= 0; k--)
        begin
            if (k >= int'(cmd.req.order) && cnt_reg[k] != '0)
            begin
                kf    = bpa_pkg::ORD_W'(k);
                kf_ok = 1'b1;
            end
        end
    end

    // lowest non-empty bitmap word of that order
    always_comb
    begin
        lo    = bpa_pkg::rgn_base(int'(kf));
        hi    = lo + bpa_pkg::rgn_words(int'(kf));
        wf    = '0;
        wf_ok = 1'b0;
        for (int w = bpa_pkg::NWORDS - 1; w >= 0; w--)
        begin
            if (sum_reg[w] && w >= lo && w < hi)
            begin
                wf    = bpa_pkg::MAP_AW'(w);
                wf_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        fb = '0;
        for (int b = bpa_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (m_rdata[b])
            begin
                fb = bpa_pkg::BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        lg = '0;
        for (int k = 1; k < bpa_pkg::ORDER_SLOTS; k++)
        begin
            if (cnt_reg[k] != '0)
            begin
                lg = bpa_pkg::ORD_W'(k);
            end
        end
    end

    assign pg_a = bpa_pkg::PG_W'(((int'(word_reg) - bpa_pkg::rgn_base(int'(lvl_reg)))
                  * bpa_pkg::WORD_W + int'(fb)) << lvl_reg);
    assign q_a  = pg_a ^ (bpa_pkg::PG_W'(1) << (lvl_reg - 1'b1));
    assign q_n  = pg_reg ^ (bpa_pkg::PG_W'(1) << (lvl_reg - 1'b1));
    assign bm   = bpa_pkg::map_bit(lvl_reg, pg_reg);
    assign sz   = bpa_pkg::CNT_W'(1) << ord_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ord_next       = ord_reg;
        pg_next        = pg_reg;
        lvl_next       = lvl_reg;
        word_next      = word_reg;
        stat_next      = stat_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_pop;
        rsp_next       = rsp_reg;
        m_we           = 1'b0;
        m_waddr        = '0;
        m_wdata        = '0;
        m_raddr        = '0;
        h_we           = 1'b0;
        h_waddr        = '0;
        h_wdata        = '0;
        h_raddr        = '0;
        ctl.take       = 1'b0;
        ctl.init_busy  = (state_reg == S_INIT);

        unique case (state_reg)
            S_INIT:
            begin
                h_we     = 1'b1;
                h_waddr  = clr_reg;
                if (int'(clr_reg) < bpa_pkg::NWORDS)
                begin
                    m_we    = 1'b1;
                    m_waddr = bpa_pkg::MAP_AW'(clr_reg);
                    m_wdata = bpa_pkg::map_reset_word(int'(clr_reg));
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == bpa_pkg::PG_W'(bpa_pkg::PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.take = 1'b1;
                    ord_next = cmd.req.order;
                    pg_next  = cmd.req.block_page;
                    priority if (cmd.bad)
                    begin
                        stat_next  = bpa_pkg::ST_BAD_ORDER;
                        state_next = S_DONE;
                    end
                    else if (cmd.req.func == bpa_pkg::FUNC_ALLOC)
                    begin
                        if (kf_ok && wf_ok)
                        begin
                            m_raddr    = wf;
                            word_next  = wf;
                            lvl_next   = kf;
                            state_next = S_ATAKE;
                        end
                        else
                        begin
                            stat_next  = bpa_pkg::ST_NO_MEM;
                            state_next = S_DONE;
                        end
                    end
                    else if (int'(cmd.req.block_page) >= bpa_pkg::POOL_PAGES)
                    begin
                        stat_next  = bpa_pkg::ST_NOT_ALLOC;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        h_raddr    = cmd.req.block_page;
                        state_next = S_FCHK;
                    end
                end
            end
            S_ATAKE:
            begin
                m_we              = 1'b1;
                m_waddr           = word_reg;
                m_wdata           = m_rdata & ~(bpa_pkg::WORD_W'(1) << fb);
                cnt_next[lvl_reg] = cnt_reg[lvl_reg] - 1'b1;
                pg_next           = pg_a;
                if (lvl_reg == ord_reg)
                begin
                    state_next = S_AHEAD;
                end
                else
                begin
                    m_raddr    = bpa_pkg::map_addr(lvl_reg - 1'b1, q_a);
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_ASPLIT;
                end
            end
            S_ASPLIT:
            begin
                // upper buddy at this order becomes free
                m_we              = 1'b1;
                m_waddr           = bpa_pkg::map_addr(lvl_reg,
                                    pg_reg ^ (bpa_pkg::PG_W'(1) << lvl_reg));
                m_wdata           = m_rdata | (bpa_pkg::WORD_W'(1)
                                    << bpa_pkg::map_bit(lvl_reg,
                                    pg_reg ^ (bpa_pkg::PG_W'(1) << lvl_reg)));
                cnt_next[lvl_reg] = cnt_reg[lvl_reg] + 1'b1;
                if (lvl_reg == ord_reg)
                begin
                    state_next = S_AHEAD;
                end
                else
                begin
                    m_raddr    = bpa_pkg::map_addr(lvl_reg - 1'b1, q_n);
                    lvl_next   = lvl_reg - 1'b1;
                end
            end
            S_AHEAD:
            begin
                h_we       = 1'b1;
                h_waddr    = pg_reg;
                h_wdata    = ord_reg + 1'b1;
                free_next  = free_reg - sz;
                used_next  = used_reg + sz;
                peak_next  = (used_next > peak_reg) ? used_next : peak_reg;
                stat_next  = bpa_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (h_rdata != ord_reg + 1'b1)
                begin
                    stat_next  = bpa_pkg::ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else
                begin
                    h_we       = 1'b1;
                    h_waddr    = pg_reg;
                    m_raddr    = bpa_pkg::map_addr(ord_reg, pg_reg);
                    lvl_next   = ord_reg;
                    state_next = S_FMERGE;
                end
            end
            S_FMERGE:
            begin
                m_we    = 1'b1;
                m_waddr = bpa_pkg::map_addr(lvl_reg, pg_reg);
                if (lvl_reg != bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER) && m_rdata[bm ^ 1'b1])
                begin
                    // buddy free: take it and move one order up
                    m_wdata           = m_rdata & ~(bpa_pkg::WORD_W'(1) << (bm ^ 1'b1));
                    cnt_next[lvl_reg] = cnt_reg[lvl_reg] - 1'b1;
                    pg_next           = pg_reg & ~(bpa_pkg::PG_W'(1) << lvl_reg);
                    lvl_next          = lvl_reg + 1'b1;
                    m_raddr           = bpa_pkg::map_addr(lvl_reg + 1'b1, pg_next);
                end
                else
                begin
                    m_wdata           = m_rdata | (bpa_pkg::WORD_W'(1) << bm);
                    cnt_next[lvl_reg] = cnt_reg[lvl_reg] + 1'b1;
                    free_next         = free_reg + sz;
                    used_next         = used_reg - sz;
                    stat_next         = bpa_pkg::ST_OK;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg)
                begin
                    rsp_next.status         = stat_reg;
                    rsp_next.page_index     = (stat_reg == bpa_pkg::ST_OK) ? pg_reg : '0;
                    rsp_next.pages_free     = free_reg;
                    rsp_next.used_pages     = used_reg;
                    rsp_next.peak_pages     = peak_reg;
                    rsp_next.max_free_order = lg;
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
        endcase

        if (m_we)
        begin
            sum_next[m_waddr] = |m_wdata;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

    always_ff @(posedge clk)
    begin
        ord_reg  <= ord_next;
        pg_reg   <= pg_next;
        lvl_reg  <= lvl_next;
        word_reg <= word_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            sum_reg       <= bpa_pkg::SUM_INIT;
            free_reg      <= bpa_pkg::CNT_W'(bpa_pkg::POOL_PAGES);
            used_reg      <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < bpa_pkg::ORDER_SLOTS; k++)
            begin
                cnt_reg[k] <= (k == bpa_pkg::TOP_ORDER) ?
                              bpa_pkg::CNT_W'(bpa_pkg::TOP_BLOCKS) : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sum_reg       <= sum_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    `BPA_ASSERT_ALWAYS(a_page_balance, (32'(free_reg) + 32'(used_reg)) == 32'(bpa_pkg::POOL_PAGES), "free and used pages out of balance")
    `BPA_ASSERT_ALWAYS(a_peak_bound, peak_reg >= used_reg, "peak below current usage")
    `BPA_ASSERT_IMPL(a_no_rsp_in_init, state_reg == S_INIT, !rsp_valid_reg, "result during clearing pass")
    `BPA_ASSERT_IMPL(a_rsp_from_done, !rsp_valid_reg ##1 rsp_valid_reg, $past(state_reg) == S_DONE, "result loaded outside completion")

endmodule
